### src/rsmst_pkg.sv
`default_nettype none
package rsmst_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = 11;
  localparam int NODE_W     = 12;
  localparam int NODE_SLOTS = 4 * DEPTH;
  localparam int SUM_W      = 42;
  localparam int SP_W       = 4;
  localparam int ADDR_W     = 3;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_SUM = 2'd1;
  localparam logic [1:0] OP_MAX = 2'd2;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_ERR  = 1'b1;

  localparam logic [0:0] REG_ELEMENT_COUNT = 1'd0;

  typedef struct packed {
    logic signed [SUM_W-1:0]      sum;
    logic signed [VALUE_BITS-1:0] mx;
  } node_t;

  // pending right-hand part of a split range
  typedef struct packed {
    logic [CNT_W-1:0]  qb;
    logic [CNT_W-1:0]  qe;
    logic [CNT_W-1:0]  lo;
    logic [CNT_W-1:0]  hi;
    logic [NODE_W-1:0] node;
  } task_t;

endpackage
`default_nettype wire

### src/rsmst_ifs.sv
`default_nettype none
interface rsmst_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           op;
  logic [rsmst_pkg::CNT_W-1:0]          position;
  logic [rsmst_pkg::CNT_W-1:0]          range_end;
  logic signed [rsmst_pkg::VALUE_BITS-1:0] new_value;
  modport source (output valid, op, position, range_end, new_value, input ready);
  modport sink (input valid, op, position, range_end, new_value, output ready);
endinterface

interface rsmst_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsmst_pkg::SUM_W-1:0] answer;
  logic                               status;
  modport source (output valid, answer, status, input ready);
  modport sink (input valid, answer, status, output ready);
endinterface
`default_nettype wire

### src/range_sum_max_segment_tree_top.sv
`default_nettype none
// Segment tree over up to 1024 signed 32-bit values, node sums and maxima held
// in one 4096-entry memory with two registered read ports. One item is worked
// at a time. A set walks down the tree level by level to the leaf, then does a
// read and a write-back of the children's sum and maximum for each ancestor,
// with the accept and result states around it. A query walks the nodes of the
// range, bounded by the two root-to-leaf walks of the range ends. Errors and
// unknown ops go straight from the accept to the result. After reset and after
// every element_count write the memory is cleared in a pass over all 4096
// entries during which no item is accepted.
module range_sum_max_segment_tree_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  rsmst_req_if.sink                               req,
  rsmst_rsp_if.source                             rsp,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rsmst_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import rsmst_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SDESC = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SWR   = 4'd4;
  localparam logic [3:0] S_QWALK = 4'd5;
  localparam logic [3:0] S_QLAST = 4'd6;
  localparam logic [3:0] S_RESP  = 4'd7;

  localparam logic signed [VALUE_BITS-1:0] MAX_INIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  node_t mem [NODE_SLOTS];
  node_t rd_a, rd_b;

  logic [3:0]              state;
  logic [NODE_W-1:0]       clr_addr;
  logic [CNT_W-1:0]        count;
  logic [NODE_W-1:0]       node;
  logic [CNT_W-1:0]        lo, hi, qb, qe;
  logic [1:0]              op_q;
  logic signed [VALUE_BITS-1:0] val_q;
  task_t                   stack [2**SP_W];
  logic [SP_W-1:0]         sp;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [VALUE_BITS-1:0] acc_max;
  logic                    rd_pend;
  logic signed [SUM_W-1:0] res_ans;
  logic                    res_st;

  logic                    we;
  logic [NODE_W-1:0]       wa, ra, rb;
  node_t                   wd;
  logic [CNT_W-1:0]        mid;
  logic [NODE_W-1:0]       parent;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [VALUE_BITS-1:0] max_next;
  logic                    cfg_wr;
  logic [CNT_W-1:0]        cnt_clamped;
  logic                    accept, bad;
  logic                    out_free;

  assign pready   = 1'b1;
  assign prdata   = {{(32-CNT_W){1'b0}}, count};
  assign cfg_wr   = psel && penable && pwrite && (paddr[2:2] == REG_ELEMENT_COUNT);
  assign req.ready = (state == S_IDLE);
  assign accept   = req.valid && req.ready;
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    if (pwdata[CNT_W-1:0] == '0) begin
      cnt_clamped = CNT_W'(1);
    end else if (pwdata[CNT_W-1:0] > CNT_W'(DEPTH)) begin
      cnt_clamped = CNT_W'(DEPTH);
    end else begin
      cnt_clamped = pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    logic [CNT_W:0] lr;
    lr  = {1'b0, lo} + {1'b0, hi};
    mid = lr[CNT_W:1];
  end

  assign parent = node >> 1;

  always_comb begin
    if (req.op == OP_SET) begin
      bad = (req.position == '0) || (req.position > count);
    end else if (req.op == OP_SUM || req.op == OP_MAX) begin
      bad = (req.position == '0) || (req.range_end > count) ||
            (req.position > req.range_end);
    end else begin
      bad = 1'b0;
    end
  end

  // query accumulation of the node read issued last cycle
  always_comb begin
    sum_next = acc_sum;
    max_next = acc_max;
    if (rd_pend) begin
      sum_next = acc_sum + rd_a.sum;
      if (rd_a.mx > acc_max) begin
        max_next = rd_a.mx;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    wa = node;
    wd = '0;
    ra = node;
    rb = {parent[NODE_W-2:0], 1'b1};
    case (state)
      S_CLR: begin
        we = 1'b1;
        wa = clr_addr;
      end
      S_SDESC: begin
        if (lo == hi) begin
          we     = 1'b1;
          wd.sum = SUM_W'(val_q);
          wd.mx  = val_q;
        end
      end
      S_SRD: begin
        ra = {parent[NODE_W-2:0], 1'b0};
      end
      S_SWR: begin
        we     = 1'b1;
        wd.sum = rd_a.sum + rd_b.sum;
        wd.mx  = (rd_a.mx > rd_b.mx) ? rd_a.mx : rd_b.mx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      count     <= CNT_W'(DEPTH);
      rsp.valid <= 1'b0;
      rd_pend   <= 1'b0;
      sp        <= '0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == NODE_W'(NODE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q    <= req.op;
            qb      <= req.position;
            qe      <= req.range_end;
            val_q   <= req.new_value;
            lo      <= CNT_W'(1);
            hi      <= count;
            node    <= NODE_W'(1);
            acc_sum <= '0;
            acc_max <= MAX_INIT;
            sp      <= '0;
            rd_pend <= 1'b0;
            res_ans <= '0;
            res_st  <= ST_DONE;
            if (bad) begin
              res_st <= ST_ERR;
              state  <= S_RESP;
            end else if (req.op == OP_SET) begin
              state <= S_SDESC;
            end else if (req.op == OP_SUM || req.op == OP_MAX) begin
              state <= S_QWALK;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SDESC: begin
          if (lo == hi) begin
            state <= (node == NODE_W'(1)) ? S_RESP : S_SRD;
          end else if (qb <= mid) begin
            hi   <= mid;
            node <= {node[NODE_W-2:0], 1'b0};
          end else begin
            lo   <= mid + 1'b1;
            node <= {node[NODE_W-2:0], 1'b1};
          end
        end
        S_SRD: begin
          node  <= parent;
          state <= S_SWR;
        end
        S_SWR: begin
          state <= (node == NODE_W'(1)) ? S_RESP : S_SRD;
        end
        S_QWALK: begin
          acc_sum <= sum_next;
          acc_max <= max_next;
          rd_pend <= 1'b0;
          if (qb == lo && qe == hi) begin
            rd_pend <= 1'b1;
            if (sp != '0) begin
              qb   <= stack[sp-1'b1].qb;
              qe   <= stack[sp-1'b1].qe;
              lo   <= stack[sp-1'b1].lo;
              hi   <= stack[sp-1'b1].hi;
              node <= stack[sp-1'b1].node;
              sp   <= sp - 1'b1;
            end else begin
              state <= S_QLAST;
            end
          end else if (qe <= mid) begin
            hi   <= mid;
            node <= {node[NODE_W-2:0], 1'b0};
          end else if (qb > mid) begin
            lo   <= mid + 1'b1;
            node <= {node[NODE_W-2:0], 1'b1};
          end else begin
            stack[sp] <= '{qb: mid + 1'b1, qe: qe, lo: mid + 1'b1, hi: hi,
                           node: {node[NODE_W-2:0], 1'b1}};
            sp   <= sp + 1'b1;
            qe   <= mid;
            hi   <= mid;
            node <= {node[NODE_W-2:0], 1'b0};
          end
        end
        S_QLAST: begin
          rd_pend <= 1'b0;
          res_ans <= (op_q == OP_SUM) ? sum_next : SUM_W'(max_next);
          state   <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            rsp.valid  <= 1'b1;
            rsp.answer <= res_ans;
            rsp.status <= res_st;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_wr) begin
        count    <= cnt_clamped;
        clr_addr <= '0;
        state    <= S_CLR;
      end
    end
  end

endmodule
`default_nettype wire

### src/rsmst_chk.sv
`default_nettype none
module rsmst_chk (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_ready,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic signed [rsmst_pkg::SUM_W-1:0] rsp_answer,
  input wire logic                               rsp_status
);
  import rsmst_pkg::*;

  // a waiting result is not dropped
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_ERR |-> rsp_answer == '0)
    else $error("error result with nonzero answer");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while busy");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_ready)
    else $error("activity right after reset");

endmodule

bind range_sum_max_segment_tree_top rsmst_chk u_rsmst_chk (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_answer(rsp.answer),
  .rsp_status(rsp.status)
);
`default_nettype wire
